/* src/raycast_column_setup_core_defines.svh */
// ----------------------------------------------------------------------------
// raycast column setup - assertion macros
// shared property forms for the checker; clk and rst come from the enclosing scope
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_SETUP_CORE_DEFINES_SVH
`define RAYCAST_COLUMN_SETUP_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RCS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked after the delay given by dly, counted from the antecedent
`define RCS_CHECK_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* src/rcs_pkg.sv */
// ----------------------------------------------------------------------------
// rcs_pkg
// types and constants shared by the ray setup pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // one quotient bit per divider cell
  localparam int DIV_STEPS  = 31;
  // pipeline depth of the ray direction unit
  localparam int RAY_STAGES = 6;
  // column register + ray unit + divider chain + side multiply + output register
  localparam int LATENCY    = 1 + RAY_STAGES + DIV_STEPS + 2;

  typedef enum logic [2:0] {
    CFG_VIEW_DIR_X  = 3'd0,
    CFG_VIEW_DIR_Y  = 3'd1,
    CFG_CAM_PLANE_X = 3'd2,
    CFG_CAM_PLANE_Y = 3'd3,
    CFG_PLAYER_X    = 3'd4,
    CFG_PLAYER_Y    = 3'd5
  } cfg_reg_t;

  // what travels down the divider chain for one axis
  typedef struct packed {
    logic signed [16:0] ray;
    logic [16:0]        divisor;
    logic [15:0]        rem;
    logic [30:0]        qn;       // numerator bits shift out on top, quotient bits in below
  } div_cell_t;

endpackage

`default_nettype wire

/* src/rcs_div_cell.sv */
// ----------------------------------------------------------------------------
// rcs_div_cell
// one restoring division step, registered, handing its result to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_div_cell
  import rcs_pkg::*;
(
  input  logic      clk,
  input  div_cell_t cell_in,
  output div_cell_t cell_out
);

  logic [16:0] rem_sh;
  logic [17:0] trial;
  logic        fits;
  div_cell_t   cell_next;

  always_comb begin
    rem_sh    = {cell_in.rem, cell_in.qn[30]};
    trial     = {1'b0, rem_sh} - {1'b0, cell_in.divisor};
    fits      = ~trial[17];
    cell_next = cell_in;
    cell_next.rem = fits ? trial[15:0] : rem_sh[15:0];
    cell_next.qn  = {cell_in.qn[29:0], fits};
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_next;
  end

endmodule

`default_nettype wire

/* src/rcs_ray_unit.sv */
// ----------------------------------------------------------------------------
// rcs_ray_unit
// ray component dir + plane * (2*col - W) / W, rounded, then divider operands
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_ray_unit
  import rcs_pkg::*;
#(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic               clk,
  input  logic [9:0]         col,
  input  logic signed [15:0] dir,
  input  logic signed [15:0] plane,
  output div_cell_t          cell_init
);

  // floor division by D done as a reciprocal multiply on a biased, nonnegative numerator
  localparam int D   = 2 * SCREEN_WIDTH;
  localparam int K   = ((2 ** 28) + D - 1) / D;
  localparam int M   = (2 ** 30) / D;
  localparam int OFS = SCREEN_WIDTH + K * D;

  localparam logic signed [13:0] W_S   = 14'(SCREEN_WIDTH);
  localparam logic signed [30:0] OFS_S = 31'(OFS);
  localparam logic signed [30:0] K_S   = 31'(K);
  localparam logic [29:0]        M_U   = 30'(M);
  localparam logic [13:0]        D_U   = 14'(D);
  localparam logic [29:0]        D_W   = 30'(D);

  logic signed [13:0] diff;
  logic signed [29:0] prod_full;
  logic signed [29:0] prod_a;

  logic signed [30:0] n_sum;
  logic [29:0]        n_cur;
  logic [59:0]        mul_full;
  logic [29:0]        n_b;
  logic [27:0]        qe_b;

  logic [41:0]        qd_full;
  logic [29:0]        n_c;
  logic [27:0]        qe_c;
  logic [29:0]        qd_c;

  logic [29:0]        rem_d;
  logic               bump;
  logic [27:0]        q_d;

  logic signed [30:0] ray_raw;
  logic signed [16:0] ray_sat;
  logic signed [16:0] ray_e;

  logic [16:0]        mag;
  div_cell_t          init_next;

  always_comb begin
    diff      = $signed({3'b000, col, 1'b0}) - W_S;
    prod_full = plane * diff;

    n_sum    = $signed({prod_a, 1'b0}) + OFS_S;
    n_cur    = n_sum[29:0];
    mul_full = n_cur * M_U;

    qd_full = qe_b * D_U;

    rem_d = n_c - qd_c;
    bump  = (rem_d >= D_W);

    ray_raw = $signed({3'b000, q_d}) - K_S + $signed({{15{dir[15]}}, dir});
    if (ray_raw > 31'sd65535) begin
      ray_sat = 17'sd65535;
    end else if (ray_raw < -31'sd65536) begin
      ray_sat = -17'sd65536;
    end else begin
      ray_sat = ray_raw[16:0];
    end

    // |ray| of -65536 is 65536, still exact as an unsigned 17-bit value
    mag = ray_e[16] ? (17'd0 - $unsigned(ray_e)) : $unsigned(ray_e);
    init_next.ray     = ray_e;
    init_next.divisor = mag;
    init_next.rem     = '0;
    init_next.qn      = 31'h4000_0000 + {15'b0, mag[16:1]};
  end

  always_ff @(posedge clk) begin
    prod_a    <= prod_full;
    n_b       <= n_cur;
    qe_b      <= mul_full[57:30];
    n_c       <= n_b;
    qe_c      <= qe_b;
    qd_c      <= qd_full[29:0];
    q_d       <= qe_c + {27'b0, bump};
    ray_e     <= ray_sat;
    cell_init <= init_next;
  end

endmodule

`default_nettype wire

/* src/raycast_column_setup_core.sv */
// ----------------------------------------------------------------------------
// raycast_column_setup_core
// per-column ray setup for grid raycasting: ray direction, start cell,
// step signs, delta distances and initial side distances
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  input     start, busy, column                      command in
//  result    done + ray/cell/step/delta/side ports    strobe out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data write in
//
//  one column accepted per clock while busy is low; the pipeline depth is
//  dominated by the 31-cell restoring divider chain for 1/|ray|
//  busy is held high and cfg_ready low during reset and in the cycle after it
//  reset restores the default camera; results cannot be held off downstream
// ----------------------------------------------------------------------------
`default_nettype none

module raycast_column_setup_core
  import rcs_pkg::*;
#(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               start,
  output logic               busy,
  input  logic [9:0]         column,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,

  output logic               done,
  output logic signed [16:0] ray_dir_x,
  output logic signed [16:0] ray_dir_y,
  output logic [7:0]         cell_x,
  output logic [7:0]         cell_y,
  output logic               step_x_negative,
  output logic               step_y_negative,
  output logic [31:0]        delta_dist_x,
  output logic [31:0]        delta_dist_y,
  output logic [31:0]        side_dist_x,
  output logic [31:0]        side_dist_y
);

  logic signed [15:0] view_dir_x;
  logic signed [15:0] view_dir_y;
  logic signed [15:0] cam_plane_x;
  logic signed [15:0] cam_plane_y;
  logic [23:0]        player_x;
  logic [23:0]        player_y;

  logic               accept;
  logic [LATENCY-1:0] vpipe;
  logic [9:0]         col_q;

  logic signed [15:0] dir_sel   [2];
  logic signed [15:0] plane_sel [2];
  logic [15:0]        frac_sel  [2];

  div_cell_t          chain [2][DIV_STEPS+1];

  logic [47:0]        side_prod [2];
  logic signed [16:0] ray_s     [2];
  logic [30:0]        delta_s   [2];

  logic signed [16:0] ray_o     [2];
  logic               neg_o     [2];
  logic [31:0]        delta_o   [2];
  logic [31:0]        side_o    [2];
  logic [7:0]         cell_o    [2];

  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;
  assign done      = vpipe[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_dir_x  <= 16'sd16384;
      view_dir_y  <= 16'sd0;
      cam_plane_x <= 16'sd0;
      cam_plane_y <= 16'sd10813;
      player_x    <= 24'd0;
      player_y    <= 24'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VIEW_DIR_X:  view_dir_x  <= cfg_data[15:0];
        CFG_VIEW_DIR_Y:  view_dir_y  <= cfg_data[15:0];
        CFG_CAM_PLANE_X: cam_plane_x <= cfg_data[15:0];
        CFG_CAM_PLANE_Y: cam_plane_y <= cfg_data[15:0];
        CFG_PLAYER_X:    player_x    <= cfg_data;
        CFG_PLAYER_Y:    player_y    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    col_q <= column;
  end

  assign dir_sel[0]   = view_dir_x;
  assign dir_sel[1]   = view_dir_y;
  assign plane_sel[0] = cam_plane_x;
  assign plane_sel[1] = cam_plane_y;
  assign frac_sel[0]  = player_x[15:0];
  assign frac_sel[1]  = player_y[15:0];
  assign cell_o[0]    = player_x[23:16];
  assign cell_o[1]    = player_y[23:16];

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [16:0] gap;
    logic [47:0] prod_next;
    logic [48:0] rounded;
    logic        zero;

    rcs_ray_unit #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
    ) u_ray (
      .clk      (clk),
      .col      (col_q),
      .dir      (dir_sel[a]),
      .plane    (plane_sel[a]),
      .cell_init(chain[a][0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rcs_div_cell u_cell (
        .clk     (clk),
        .cell_in (chain[a][i]),
        .cell_out(chain[a][i+1])
      );
    end

    // distance to the first grid line: fraction behind or ahead of the player
    always_comb begin
      gap = chain[a][DIV_STEPS].ray[16] ? {1'b0, frac_sel[a]}
                                         : (17'h1_0000 - {1'b0, frac_sel[a]});
      prod_next = gap * chain[a][DIV_STEPS].qn;
      rounded   = {1'b0, side_prod[a]} + 49'd32768;
      zero      = (ray_s[a] == 17'sd0);
    end

    always_ff @(posedge clk) begin
      side_prod[a] <= prod_next;
      ray_s[a]     <= chain[a][DIV_STEPS].ray;
      delta_s[a]   <= chain[a][DIV_STEPS].qn;

      ray_o[a] <= ray_s[a];
      neg_o[a] <= ray_s[a][16];
      if (zero) begin
        delta_o[a] <= '1;
        side_o[a]  <= '1;
      end else begin
        delta_o[a] <= {1'b0, delta_s[a]};
        side_o[a]  <= rounded[48] ? '1 : rounded[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_x <= cell_o[0];
    cell_y <= cell_o[1];
  end

  assign ray_dir_x       = ray_o[0];
  assign ray_dir_y       = ray_o[1];
  assign step_x_negative = neg_o[0];
  assign step_y_negative = neg_o[1];
  assign delta_dist_x    = delta_o[0];
  assign delta_dist_y    = delta_o[1];
  assign side_dist_x     = side_o[0];
  assign side_dist_y     = side_o[1];

endmodule

`default_nettype wire

/* src/rcs_checker.sv */
// ----------------------------------------------------------------------------
// rcs_checker
// port-level checks on the ray setup core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "raycast_column_setup_core_defines.svh"

module rcs_checker
  import rcs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [16:0] ray_dir_x,
  input logic signed [16:0] ray_dir_y,
  input logic               step_x_negative,
  input logic               step_y_negative,
  input logic [31:0]        delta_dist_x,
  input logic [31:0]        delta_dist_y,
  input logic [31:0]        side_dist_x,
  input logic [31:0]        side_dist_y
);

  // every accepted item comes out after the fixed pipeline depth
  `RCS_CHECK_LATER(a_item_done, start && !busy, LATENCY, done, "item lost in pipeline")

  // no result without an item accepted at the matching time
  `RCS_CHECK(a_done_has_item, done, $past(start && !busy, LATENCY), "spurious result")

  // step sign follows the sign of the delivered ray
  `RCS_CHECK(a_step_sign, done, (step_x_negative == ray_dir_x[16]) && (step_y_negative == ray_dir_y[16]), "step sign mismatch")

  // a zero ray component saturates both distances on that axis
  `RCS_CHECK(a_zero_ray, done && ((ray_dir_x == 17'sd0) || (ray_dir_y == 17'sd0)), ((ray_dir_x != 17'sd0) || ((delta_dist_x == 32'hFFFF_FFFF) && (side_dist_x == 32'hFFFF_FFFF))) && ((ray_dir_y != 17'sd0) || ((delta_dist_y == 32'hFFFF_FFFF) && (side_dist_y == 32'hFFFF_FFFF))), "zero ray not saturated")

endmodule

bind raycast_column_setup_core rcs_checker u_rcs_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .ray_dir_x      (ray_dir_x),
  .ray_dir_y      (ray_dir_y),
  .step_x_negative(step_x_negative),
  .step_y_negative(step_y_negative),
  .delta_dist_x   (delta_dist_x),
  .delta_dist_y   (delta_dist_y),
  .side_dist_x    (side_dist_x),
  .side_dist_y    (side_dist_y)
);

`default_nettype wire
